// ===== sv/pbs_pkg.sv =====
// types and constants shared by the parity bit-stuffing serializer
// no dependencies
package pbs_pkg;

  localparam int unsigned DataBits = 8;
  localparam int unsigned WordBits = DataBits + 1;

  // zero run length after which a stuffed one is sent
  localparam logic [2:0] RunLimit = 3'd4;

  // index of the parity bit within the emitted word
  localparam logic [3:0] LastIdx = 4'(DataBits);

  // one classified item: data bits msb first followed by even parity
  typedef struct packed {
    logic                first;
    logic [WordBits-1:0] bits;
  } item_t;

endpackage

// ===== sv/pbs_front.sv =====
// front end: accepts bytes, computes parity and forms queue items
// depends on pbs_pkg
module pbs_front (
  input  logic       [7:0] data_byte,
  input  logic             first_of_frame,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             q_full,
  output logic             q_push,
  output pbs_pkg::item_t   q_item
);

  // take a transfer whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // even parity and packing
  always_comb begin
    q_item.first = first_of_frame;
    q_item.bits  = {data_byte, ^data_byte};
  end

endmodule

// ===== sv/pbs_queue.sv =====
// short queue between the front end and the serializer
// depends on pbs_pkg
module pbs_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pbs_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output pbs_pkg::item_t head
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  pbs_pkg::item_t    slots [Depth];
  logic [AddrW-1:0]  wr_ptr;
  logic [AddrW-1:0]  rd_ptr;
  logic [CountW-1:0] count;

  assign full      = (count == CountW'(Depth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AddrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AddrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/pbs_back.sv =====
// back end: start bit, data, parity, zero-bit stuffing; a bit a cycle if ready
// depends on pbs_pkg
module pbs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_not_empty,
  input  pbs_pkg::item_t q_head,
  output logic           q_pop,
  output logic           line_bit,
  output logic           last_of_item,
  output logic           out_valid,
  input  logic           out_ready
);

  logic                         busy;
  logic                         start_pend;
  logic [pbs_pkg::WordBits-1:0] word;
  logic [3:0]                   idx;
  logic [2:0]                   zero_run;

  logic                         advance;
  logic                         load;
  logic                         bit_next;
  logic                         last_next;
  logic                         start_pend_next;
  logic [pbs_pkg::WordBits-1:0] word_next;
  logic [3:0]                   idx_next;
  logic [2:0]                   zero_run_next;

  // output register free or being drained
  assign advance = busy && (!out_valid || out_ready);
  assign load    = q_not_empty && (!busy || (advance && last_next));
  assign q_pop   = load;

  // choose the next line bit
  always_comb begin
    bit_next        = 1'b1;
    last_next       = 1'b0;
    start_pend_next = start_pend;
    word_next       = word;
    idx_next        = idx;
    zero_run_next   = zero_run;
    if (start_pend) begin
      start_pend_next = 1'b0;
      zero_run_next   = '0;
    end else if (zero_run >= pbs_pkg::RunLimit) begin
      zero_run_next = '0;
    end else begin
      bit_next      = word[pbs_pkg::WordBits-1];
      word_next     = {word[pbs_pkg::WordBits-2:0], 1'b0};
      idx_next      = idx + 1'b1;
      last_next     = (idx == pbs_pkg::LastIdx);
      zero_run_next = bit_next ? 3'd0 : zero_run + 1'b1;
    end
  end

  // serializer state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      start_pend <= 1'b0;
      idx        <= '0;
      zero_run   <= '0;
    end else begin
      if (advance) begin
        zero_run <= zero_run_next;
      end
      if (load) begin
        busy       <= 1'b1;
        start_pend <= q_head.first;
        idx        <= '0;
      end else if (advance) begin
        busy       <= !last_next;
        start_pend <= start_pend_next;
        idx        <= idx_next;
      end
    end
  end

  // shift word, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      word <= q_head.bits;
    end else if (advance) begin
      word <= word_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      line_bit     <= bit_next;
      last_of_item <= last_next;
    end
  end

endmodule

// ===== sv/parity_bit_stuffing_serializer.sv =====
// zero-bit stuffing serializer with even parity and leading start bit
// a byte goes through a queue slot, the shift word and the output register
// one line bit per cycle from the shift word while out_ready does not stall it
// a queue of QDepth bytes decouples input transfers from serialization
// reset (rst, synchronous) empties the queue and output and clears the zero run
// depends on pbs_pkg, pbs_front, pbs_queue, pbs_back
module parity_bit_stuffing_serializer #(
  parameter int unsigned QDepth = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       first_of_frame,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       line_bit,
  output logic       last_of_item,
  output logic       out_valid,
  input  logic       out_ready
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_not_empty;
  pbs_pkg::item_t q_item;
  pbs_pkg::item_t q_head;

  // accept and classify
  pbs_front u_front (
    .data_byte      (data_byte),
    .first_of_frame (first_of_frame),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_item)
  );

  // decoupling queue
  pbs_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // serialize
  pbs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .line_bit     (line_bit),
    .last_of_item (last_of_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

endmodule

// ===== dv/parity_bit_stuffing_serializer_tb.sv =====
// self-checking bench for the parity bit-stuffing serializer: directed rows, then random frames
// depends on pbs_pkg and parity_bit_stuffing_serializer
`timescale 1ns / 1ps

module parity_bit_stuffing_serializer_tb;

  localparam int unsigned RandomBytes = 450;
  localparam int unsigned MaxBits = 12;

  // line bits caused by one byte, first bit in the msb, left aligned
  typedef struct {
    logic [MaxBits-1:0] bits;
    int unsigned        n;
  } line_burst_t;

  // one expected line bit transfer
  typedef struct packed {
    logic line_bit;
    logic last_of_item;
  } line_out_t;

  // directed row; hand-typed bits are used only where typed is set
  typedef struct {
    logic [7:0]         data;
    logic               first;
    logic               typed;
    logic [MaxBits-1:0] bits;
    int unsigned        n;
  } byte_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] data_byte = '0;
  logic       first_of_frame = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       line_bit;
  logic       last_of_item;
  logic       out_valid;
  logic       out_ready = 1'b0;

  logic [2:0] zeros_seen;
  logic       calm = 1'b0;
  int unsigned n_mismatches = 0;
  line_out_t  line_bits_due[$];
  byte_row_t  byte_rows [16];

  always #4 clk = ~clk;

  parity_bit_stuffing_serializer dut (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .first_of_frame (first_of_frame),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .line_bit       (line_bit),
    .last_of_item   (last_of_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready)
  );

  task automatic note_mismatch(input string what);
    n_mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // start bit if f is set, data msb first, even parity, a stuffed one ahead of any bit after four zeros
  function automatic line_burst_t serialize_byte(input logic [7:0] b, input logic f);
    line_burst_t r;
    logic [pbs_pkg::DataBits:0] word;
    r.bits = '0;
    r.n = 0;
    word = {b, ^b};
    if (f) begin
      r.bits[MaxBits-1] = 1'b1;
      r.n = 1;
      zeros_seen = '0;
    end
    for (int i = int'(pbs_pkg::DataBits); i >= 0; i--) begin
      if (zeros_seen >= pbs_pkg::RunLimit) begin
        r.bits[MaxBits-1-r.n] = 1'b1;
        r.n++;
        zeros_seen = '0;
      end
      r.bits[MaxBits-1-r.n] = word[i];
      r.n++;
      zeros_seen = word[i] ? 3'd0 : zeros_seen + 3'd1;
    end
    return r;
  endfunction

  task automatic queue_burst(input line_burst_t r);
    line_out_t o;
    for (int unsigned k = 0; k < r.n; k++) begin
      o.line_bit = r.bits[MaxBits-1-k];
      o.last_of_item = (k == r.n - 1);
      line_bits_due.push_back(o);
    end
  endtask

  // present one byte, optionally after an idle gap, and hold it until the transfer
  task automatic send_byte(input byte_row_t row);
    line_burst_t predicted;
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= row.data;
    first_of_frame <= row.first;
    do @(posedge clk); while (!in_ready);
    predicted = serialize_byte(row.data, row.first);
    if (row.typed) begin
      predicted.bits = row.bits;
      predicted.n = row.n;
    end
    queue_burst(predicted);
  endtask

  // half random bytes, the rest mostly sparse, trailing-zero or zero bytes so that stuffing happens often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      4, 5:    return 8'($urandom) & 8'($urandom) & 8'($urandom);
      6:       return 8'($urandom) & 8'hF8;
      7:       return 8'h00;
      8:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // receiver with random back-pressure
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 17);
  end

  // compare each output transfer with the oldest expected line bit
  always @(posedge clk) begin
    line_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (line_bits_due.size() == 0) begin
        note_mismatch($sformatf("unexpected line bit %b", line_bit));
      end else begin
        want = line_bits_due.pop_front();
        if (line_bit !== want.line_bit)
          note_mismatch($sformatf("line_bit %b, expected %b", line_bit, want.line_bit));
        if (last_of_item !== want.last_of_item)
          note_mismatch($sformatf("last_of_item %b, expected %b",
                                  last_of_item, want.last_of_item));
      end
    end
  end

  initial begin
    byte_rows = '{
      // zero byte before any frame start: two stuffs, no start bit
      '{8'h00, 1'b0, 1'b1, 12'b0000_1000_0100, 11},
      '{8'hFF, 1'b1, 1'b1, 12'b1111_1111_1000, 10},
      // zero byte opening a frame: longest burst
      '{8'h00, 1'b1, 1'b1, 12'b1000_0100_0010, 12},
      // parity completes four zeros, stuff carried to the next byte
      '{8'h18, 1'b1, 1'b0, '0, 0},
      '{8'h55, 1'b0, 1'b0, '0, 0},
      '{8'h18, 1'b0, 1'b0, '0, 0},
      // carried stuff dropped by a new frame
      '{8'hA5, 1'b1, 1'b0, '0, 0},
      '{8'h80, 1'b0, 1'b0, '0, 0},
      '{8'h01, 1'b0, 1'b0, '0, 0},
      '{8'h7F, 1'b0, 1'b0, '0, 0},
      '{8'hFE, 1'b1, 1'b0, '0, 0},
      '{8'h0F, 1'b0, 1'b0, '0, 0},
      '{8'hF0, 1'b0, 1'b0, '0, 0},
      '{8'h08, 1'b0, 1'b0, '0, 0},
      '{8'h00, 1'b0, 1'b0, '0, 0},
      '{8'h00, 1'b0, 1'b0, '0, 0}
    };
  end

  // stimulus and end of run
  initial begin
    byte_row_t row;
    int unsigned sent;
    int unsigned frame_len;
    zeros_seen = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (byte_rows[i]) send_byte(byte_rows[i]);

    // random frames; now and then a frame opens without its start bit
    sent = 0;
    row.typed = 1'b0;
    row.bits = '0;
    row.n = 0;
    while (sent < RandomBytes) begin
      frame_len = $urandom_range(8, 1);
      for (int unsigned k = 0; k < frame_len; k++) begin
        calm = (sent >= 150 && sent < 260);
        row.data = pick_byte();
        row.first = (k == 0) ? ($urandom_range(7) != 0) : ($urandom_range(15) == 0);
        send_byte(row);
        sent++;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (line_bits_due.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (n_mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
